FILE: hdl/rbad_pkg.sv
// Package for the RGB box-average downscaler: sizes, payload structs,
// line store entry type and configuration register indexes.
// No dependencies.
`default_nettype none

package rbad_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_FACTOR = 16;

    localparam int PIX_W  = 8;                          // one color byte
    localparam int FAC_W  = $clog2(MAX_FACTOR);         // offset inside a block
    localparam int COL_W  = $clog2(MAX_WIDTH);          // column / line store index
    localparam int ROW_W  = 16;                         // row position
    localparam int RUN_W  = PIX_W + FAC_W;              // sum of one block row
    localparam int SUM_W  = PIX_W + 2 * FAC_W;          // sum of a whole block
    localparam int CNT_W  = 2 * FAC_W + 1;              // pixel count of a block
    localparam int REM_W  = 2 * FAC_W;                  // divider remainder
    localparam int STEP_W = $clog2(SUM_W);              // divider step counter

    localparam int XF_W   = 5;
    localparam int YF_W   = 5;
    localparam int IW_W   = 13;
    localparam int IH_W   = 16;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_X_FACTOR     = 2'd0,
        CFG_Y_FACTOR     = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
    } in_pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             row_end;
        logic             frame_end;
    } out_pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } band_sum_t;

endpackage

`default_nettype wire

FILE: hdl/rbad_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rbad_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rgb_box_average_downscale_top.sv
// Top level of the RGB box-average downscaler: position tracking, sequencer,
// shared restoring divider and output register. Uses rbad_pkg and rbad_ram.
//
// Usage:
//   s_* channel: one 24-bit RGB pixel per transaction, raster order.
//   m_* channel: one averaged pixel per completed block, with row_end on the
//     last pixel of an output row and frame_end on the last of the image.
//   cfg_* channel: register writes (x_factor, y_factor, image_width,
//     image_height); always ready, only to be used while the block is idle.
// Sequence:
//   A pixel that does not close a block only updates positions and row sums.
//   A pixel that closes a block but not a band goes through read, add, write back.
//   A pixel that closes a block in the last row of a band goes through read and
//     add, then 16 divider steps for each channel, then a load of the output
//     register once it is free. The single shared restoring divider works one
//     quotient bit per cycle, red, then green, then blue.
// Stall: the result sits in the output register; the next pixel is taken
//   meanwhile, and a following result waits for the register to free, with s_ready low.
// Reset: synchronous, active low; positions and sums clear, registers to 1, line store kept.
`default_nettype none

module rgb_box_average_downscale_top
    import rbad_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // pixel input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_pixel_t             s_data,
    // averaged output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_pixel_t                 m_data,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // ---------------- configuration ----------------
    logic [XF_W-1:0] x_factor_reg;
    logic [YF_W-1:0] y_factor_reg;
    logic [IW_W-1:0] image_width_reg;
    logic [IH_W-1:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_factor_reg     <= XF_W'(1);
            y_factor_reg     <= YF_W'(1);
            image_width_reg  <= IW_W'(1);
            image_height_reg <= IH_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_X_FACTOR:     x_factor_reg     <= cfg_data[XF_W-1:0];
                CFG_Y_FACTOR:     y_factor_reg     <= cfg_data[YF_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped "last index" values: zero counts as 1, large values saturate.
    logic [FAC_W-1:0] xf_last;
    logic [FAC_W-1:0] yf_last;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    always_comb begin
        if (x_factor_reg == '0) begin
            xf_last = '0;
        end else if (32'(x_factor_reg) > MAX_FACTOR) begin
            xf_last = FAC_W'(MAX_FACTOR - 1);
        end else begin
            xf_last = FAC_W'(x_factor_reg - 1'b1);
        end
        if (y_factor_reg == '0) begin
            yf_last = '0;
        end else if (32'(y_factor_reg) > MAX_FACTOR) begin
            yf_last = FAC_W'(MAX_FACTOR - 1);
        end else begin
            yf_last = FAC_W'(y_factor_reg - 1'b1);
        end
        if (image_width_reg == '0) begin
            w_last = '0;
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(image_width_reg - 1'b1);
        end
        if (image_height_reg == '0) begin
            h_last = '0;
        end else begin
            h_last = ROW_W'(image_height_reg - 1'b1);
        end
    end

    // ---------------- positions and block flags ----------------
    state_t state_reg, state_next;

    logic [COL_W-1:0] col_pos_reg;
    logic [ROW_W-1:0] row_pos_reg;
    logic [FAC_W-1:0] cib_reg;          // column inside block
    logic [FAC_W-1:0] rib_reg;          // row inside band
    logic [RUN_W-1:0] run_r_reg, run_g_reg, run_b_reg;

    logic in_accept;
    logic last_col, last_row, block_end, band_end;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    assign last_col  = (col_pos_reg >= w_last);
    assign last_row  = (row_pos_reg >= h_last);
    assign block_end = last_col || (cib_reg >= xf_last);
    assign band_end  = last_row || (rib_reg >= yf_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            cib_reg     <= '0;
            rib_reg     <= '0;
            run_r_reg   <= '0;
            run_g_reg   <= '0;
            run_b_reg   <= '0;
        end else if (in_accept) begin
            if (block_end) begin
                run_r_reg <= '0;
                run_g_reg <= '0;
                run_b_reg <= '0;
            end else begin
                run_r_reg <= run_r_reg + RUN_W'(s_data.in_red);
                run_g_reg <= run_g_reg + RUN_W'(s_data.in_green);
                run_b_reg <= run_b_reg + RUN_W'(s_data.in_blue);
            end
            if (last_col) begin
                col_pos_reg <= '0;
                cib_reg     <= '0;
                if (last_row) begin
                    row_pos_reg <= '0;
                    rib_reg     <= '0;
                end else begin
                    row_pos_reg <= row_pos_reg + 1'b1;
                    rib_reg     <= band_end ? '0 : rib_reg + 1'b1;
                end
            end else begin
                col_pos_reg <= col_pos_reg + 1'b1;
                cib_reg     <= block_end ? '0 : cib_reg + 1'b1;
            end
        end
    end

    // ---------------- block context captured at the closing pixel ----------------
    band_sum_t        tot_reg, tot_next;
    logic [COL_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic             rib_nz_reg;
    logic             band_end_l_reg;
    logic             last_col_l_reg;
    logic             last_row_l_reg;

    logic [CNT_W-1:0] count_calc;
    assign count_calc = CNT_W'({1'b0, cib_reg} + 1'b1) * CNT_W'({1'b0, rib_reg} + 1'b1);

    // ---------------- line store ----------------
    band_sum_t ram_rd_data;
    logic      ram_wr_en;
    logic      ram_rd_en;
    band_sum_t band_add;

    assign ram_rd_en = (state_reg == ST_READ);
    assign ram_wr_en = (state_reg == ST_ADD) && !band_end_l_reg;

    rbad_ram #(
        .DATA_W ($bits(band_sum_t)),
        .DEPTH  (MAX_WIDTH)
    ) u_band_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (band_add),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // Entry only counts from the second row of a band on.
    always_comb begin
        band_add = tot_reg;
        if (rib_nz_reg) begin
            band_add.r = tot_reg.r + ram_rd_data.r;
            band_add.g = tot_reg.g + ram_rd_data.g;
            band_add.b = tot_reg.b + ram_rd_data.b;
        end
    end

    // ---------------- shared restoring divider ----------------
    logic [1:0]        div_ch_reg, div_ch_next;
    logic [STEP_W-1:0] div_step_reg, div_step_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  dq_reg, dq_next;      // dividend shifts out, quotient in
    logic [PIX_W-1:0]  q_r_reg, q_g_reg, q_b_reg;

    logic [CNT_W-1:0]  trial;
    logic [CNT_W-1:0]  diff;
    logic              q_bit;
    logic [SUM_W-1:0]  dq_shift;
    logic [PIX_W-1:0]  q_sat;
    logic [SUM_W-1:0]  next_dividend;

    assign trial    = {rem_reg, dq_reg[SUM_W-1]};
    assign q_bit    = (trial >= count_reg);
    assign diff     = trial - count_reg;
    assign dq_shift = {dq_reg[SUM_W-2:0], q_bit};
    assign q_sat    = (dq_shift[SUM_W-1:PIX_W] != '0) ? '1 : dq_shift[PIX_W-1:0];

    always_comb begin
        case (div_ch_reg)
            2'd0:    next_dividend = tot_reg.g;
            default: next_dividend = tot_reg.b;
        endcase
    end

    // ---------------- sequencer ----------------
    logic       m_valid_reg, m_valid_next;
    out_pixel_t m_data_reg;
    logic       load_out;

    always_comb begin
        state_next    = state_reg;
        tot_next      = tot_reg;
        div_ch_next   = div_ch_reg;
        div_step_next = div_step_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        load_out      = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && block_end) begin
                    tot_next.r = SUM_W'(run_r_reg) + SUM_W'(s_data.in_red);
                    tot_next.g = SUM_W'(run_g_reg) + SUM_W'(s_data.in_green);
                    tot_next.b = SUM_W'(run_b_reg) + SUM_W'(s_data.in_blue);
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                tot_next = band_add;
                if (band_end_l_reg) begin
                    dq_next       = band_add.r;
                    rem_next      = '0;
                    div_step_next = '0;
                    div_ch_next   = '0;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                rem_next      = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];
                dq_next       = dq_shift;
                div_step_next = div_step_reg + 1'b1;
                if (div_step_reg == STEP_W'(SUM_W - 1)) begin
                    rem_next      = '0;
                    dq_next       = next_dividend;
                    div_step_next = '0;
                    if (div_ch_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        div_ch_next = div_ch_reg + 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        tot_reg      <= tot_next;
        div_ch_reg   <= div_ch_next;
        div_step_reg <= div_step_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        if (in_accept) begin
            idx_reg        <= col_pos_reg - COL_W'(cib_reg);
            count_reg      <= count_calc;
            rib_nz_reg     <= (rib_reg != '0);
            band_end_l_reg <= band_end;
            last_col_l_reg <= last_col;
            last_row_l_reg <= last_row;
        end
        if (state_reg == ST_DIV && div_step_reg == STEP_W'(SUM_W - 1)) begin
            case (div_ch_reg)
                2'd0:    q_r_reg <= q_sat;
                2'd1:    q_g_reg <= q_sat;
                default: q_b_reg <= q_sat;
            endcase
        end
        if (load_out) begin
            m_data_reg.out_red   <= q_r_reg;
            m_data_reg.out_green <= q_g_reg;
            m_data_reg.out_blue  <= q_b_reg;
            m_data_reg.row_end   <= last_col_l_reg;
            m_data_reg.frame_end <= last_col_l_reg && last_row_l_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sim/rgb_box_average_downscale_top_test.sv
// Self-checking testbench for rgb_box_average_downscale_top: streams RGB frames
// under random flow control and checks every averaged pixel against a local predictor.
// Depends on rbad_pkg and the rgb_box_average_downscale_top RTL.
module rgb_box_average_downscale_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbad_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 60;   // lets the DUT finish its work on the last closing pixel
    localparam int RANDOM_PIXELS = 400;
    localparam int CALM_PIXELS   = 150;  // opening stretch of the random part with no idling

    typedef enum {PX_RANDOM, PX_EXTREME, PX_WHITE, PX_BLACK} px_mode_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_pixel_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_pixel_t            m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    rgb_box_average_downscale_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    in_pixel_t  pending_pixels[$];   // pixels waiting to be driven
    out_pixel_t block_means[$];      // predicted averaged pixels, oldest first
    int         idle_pct       = 32; // chance in percent that a side idles in a cycle
    logic       pixel_taken    = 1'b0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // ------------------------------------------------------------------
    // Predictor state: register copies plus the downscaler's position
    // counters, running row sums and line store of band sums.
    // ------------------------------------------------------------------
    logic [XF_W-1:0]  xf_reg       = XF_W'(1);
    logic [YF_W-1:0]  yf_reg       = YF_W'(1);
    logic [IW_W-1:0]  width_reg    = IW_W'(1);
    logic [IH_W-1:0]  height_reg   = IH_W'(1);
    band_sum_t        line_sums [MAX_WIDTH];
    band_sum_t        run_sums     = '0;
    logic [COL_W-1:0] col_pos      = '0;
    logic [ROW_W-1:0] row_pos      = '0;
    logic [FAC_W-1:0] col_in_block = '0;
    logic [FAC_W-1:0] row_in_band  = '0;

    // Entries never written read as zero; the stimulus never reads one anyway.
    initial foreach (line_sums[i]) line_sums[i] = '0;

    // Zero counts as 1, anything above the ceiling saturates.
    function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [PIX_W-1:0] sat_mean(input int unsigned sum,
                                                  input int unsigned count);
        int unsigned q;
        q = sum / count;
        return (q > 255) ? 8'hFF : q[PIX_W-1:0];
    endfunction

    // Advance the predictor by one pixel; returns 1 when a block closes in
    // the last row of its band, with the averaged pixel in res.
    function automatic bit box_average_step(input in_pixel_t px, output out_pixel_t res);
        int unsigned      xf, yf, w, h, count;
        bit               last_col, last_row, block_end, band_end, made;
        logic [COL_W-1:0] start_col;
        band_sum_t        tot;

        xf = clamp_reg(xf_reg, MAX_FACTOR);
        yf = clamp_reg(yf_reg, MAX_FACTOR);
        w  = clamp_reg(width_reg, MAX_WIDTH);
        h  = clamp_reg(height_reg, 16'hFFFF);

        // positions left past the end by a mid-frame shrink count as the end
        last_col  = col_pos >= w - 1;
        last_row  = row_pos >= h - 1;
        block_end = last_col || (col_in_block >= xf - 1);
        band_end  = last_row || (row_in_band >= yf - 1);
        made      = 1'b0;
        res       = '0;

        run_sums.r += px.in_red;
        run_sums.g += px.in_green;
        run_sums.b += px.in_blue;

        if (block_end) begin
            start_col = col_pos - col_in_block;   // wraps modulo the line store depth
            tot = run_sums;
            if (row_in_band != 0) begin
                tot.r += line_sums[start_col].r;
                tot.g += line_sums[start_col].g;
                tot.b += line_sums[start_col].b;
            end
            if (band_end) begin
                count = (int'(col_in_block) + 1) * (int'(row_in_band) + 1);
                res.out_red   = sat_mean(tot.r, count);
                res.out_green = sat_mean(tot.g, count);
                res.out_blue  = sat_mean(tot.b, count);
                res.row_end   = last_col;
                res.frame_end = last_col && last_row;
                made = 1'b1;
            end else begin
                line_sums[start_col] = tot;
            end
            run_sums = '0;
        end

        if (last_col) begin
            col_pos      = '0;
            col_in_block = '0;
            if (last_row) begin
                row_pos     = '0;
                row_in_band = '0;
            end else begin
                row_pos++;
                row_in_band = band_end ? '0 : row_in_band + 1'b1;
            end
        end else begin
            col_pos++;
            col_in_block = block_end ? '0 : col_in_block + 1'b1;
        end
        return made;
    endfunction

    task automatic log_mismatch(input string what, input out_pixel_t want,
                                input out_pixel_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%0t: %s: expected r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b, ",
                   $time, what, want.out_red, want.out_green, want.out_blue,
                   want.row_end, want.frame_end);
            $display("got r=%0d g=%0d b=%0d row_end=%0b frame_end=%0b",
                     got.out_red, got.out_green, got.out_blue, got.row_end,
                     got.frame_end);
        end
    endtask

    // ------------------------------------------------------------------
    // Pixel driver: works on the falling edge. A new transaction is only
    // loaded once the monitor has seen the current one accepted, so valid
    // and payload hold steady while the DUT stalls. The result side's
    // ready is rolled every cycle with the same idle chance.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : pixel_driver
        if (aresetn && (!s_valid || pixel_taken)) begin
            pixel_taken = 1'b0;
            if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_data  <= pending_pixels.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. An accepted pixel
    // runs through the predictor; an accepted result is checked against
    // the oldest prediction. Also owns the run timeout.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        out_pixel_t predicted;
        out_pixel_t wanted;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rgb_box_average_downscale_top_test: errors");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                pixel_taken = 1'b1;
                if (box_average_step(s_data, predicted))
                    block_means.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (block_means.size() == 0) begin
                    log_mismatch("unexpected result transaction", '0, m_data);
                end else begin
                    wanted = block_means.pop_front();
                    if (m_data.out_red   !== wanted.out_red   ||
                        m_data.out_green !== wanted.out_green ||
                        m_data.out_blue  !== wanted.out_blue  ||
                        m_data.row_end   !== wanted.row_end   ||
                        m_data.frame_end !== wanted.frame_end)
                        log_mismatch("result mismatch", wanted, m_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_pixels(input int count, input px_mode_t mode);
        in_pixel_t px;
        repeat (count) begin
            case (mode)
                PX_WHITE: px = '1;
                PX_BLACK: px = '0;
                PX_EXTREME: begin
                    px.in_red   = $urandom_range(1) ? 8'hFF : 8'h00;
                    px.in_green = $urandom_range(1) ? 8'hFF : 8'h00;
                    px.in_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                default: px = 24'($urandom);
            endcase
            pending_pixels.push_back(px);
        end
    endtask

    // Wait until every pixel is in and every predicted result is out, then
    // let the DUT settle so a block still being folded into the line store
    // finishes before any register changes.
    task automatic drain();
        while (pending_pixels.size() != 0 || s_valid || block_means.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write transaction; the predictor copy changes on accept.
    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_X_FACTOR:     xf_reg     = value[XF_W-1:0];
            CFG_Y_FACTOR:     yf_reg     = value[YF_W-1:0];
            CFG_IMAGE_WIDTH:  width_reg  = value[IW_W-1:0];
            CFG_IMAGE_HEIGHT: height_reg = value[IH_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Full register set; sometimes with junk above the factor and width fields,
    // which the DUT must drop.
    task automatic set_config(input int unsigned x, input int unsigned y,
                              input int unsigned w, input int unsigned h);
        bit junk;
        junk = ($urandom_range(3) == 0);
        write_reg(CFG_X_FACTOR,     x | (junk ? ($urandom & 32'hFFE0) : 0));
        write_reg(CFG_Y_FACTOR,     y | (junk ? ($urandom & 32'hFFE0) : 0));
        write_reg(CFG_IMAGE_WIDTH,  w | (junk ? ($urandom & 32'hE000) : 0));
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int       random_pixels;
        int       frame_len;
        px_mode_t mode;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: a 1x1 image, so every pixel comes straight back.
        queue_pixels(1, PX_WHITE);
        queue_pixels(1, PX_BLACK);
        drain();

        // 4x2 image with 1x2 blocks: fills line store entries 0..3.
        set_config(1, 2, 4, 2);
        queue_pixels(8, PX_RANDOM);
        drain();

        // Mid-frame change of x_factor: row 0 stores 2-pixel sums, row 1
        // averages over 1x2, so the all-white means in columns 0 and 2 exceed 255 and saturate.
        set_config(2, 2, 4, 2);
        queue_pixels(4, PX_WHITE);
        drain();
        write_reg(CFG_X_FACTOR, 1 | ($urandom & 32'hFFE0));
        queue_pixels(4, PX_WHITE);
        drain();

        // Zero y_factor and height, oversize width; then shrink the width
        // under the running column so the next pixel ends row and frame.
        set_config(3, 0, 8191, 0);
        queue_pixels(5, PX_RANDOM);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 2);
        queue_pixels(1, PX_RANDOM);
        drain();

        // Single 64-pixel row, oversize x_factor saturating to 16.
        set_config(31, 16, 64, 1);
        queue_pixels(64, PX_RANDOM);
        drain();

        // Largest block, all white: biggest sum and pixel count.
        set_config(MAX_FACTOR, MAX_FACTOR, MAX_FACTOR, MAX_FACTOR);
        queue_pixels(MAX_FACTOR * MAX_FACTOR, PX_WHITE);
        drain();

        // Tallest image: after one full band, cut the height below the
        // current row so the next row becomes the last one.
        set_config(2, 4, 3, 16'hFFFF);
        queue_pixels(12, PX_EXTREME);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 3);
        queue_pixels(3, PX_EXTREME);
        drain();

        // Random frames, always complete, 1 to 3 back to back per setting.
        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            idle_pct = (random_pixels < CALM_PIXELS) ? 0 : 32;
            set_config(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 5),
                       ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 5),
                       ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(1, 20),
                       ($urandom_range(7) == 0) ? $urandom_range(10) : $urandom_range(1, 6));
            frame_len = clamp_reg(width_reg, MAX_WIDTH) * clamp_reg(height_reg, 16'hFFFF);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(7))
                    0:       mode = PX_WHITE;
                    1:       mode = PX_BLACK;
                    2, 3:    mode = PX_EXTREME;
                    default: mode = PX_RANDOM;
                endcase
                queue_pixels(frame_len, mode);
                random_pixels += frame_len;
            end
            drain();
        end

        if (mismatch_count == 0 && block_means.size() == 0) begin
            $display("rgb_box_average_downscale_top_test: clean");
        end else begin
            $display("rgb_box_average_downscale_top_test: errors");
        end
        $finish;
    end

endmodule
